// ===== src/wsp_pkg.sv =====
`timescale 1ns / 1ps

package wsp_pkg;

   localparam int unsigned COORD_W    = 32;
   localparam int unsigned CSR_W      = 31;
   localparam int unsigned DIM_W      = 14;
   localparam int unsigned HALF_W     = 13;
   localparam int unsigned THR_W      = 31;
   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned ACC_W      = 49;
   localparam int unsigned MAG_W      = 48;
   localparam int unsigned NUM_W      = 61;
   localparam int unsigned DIV_STEPS  = 33;
   localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
   localparam int unsigned MAT_IDX_W  = 4;
   localparam int unsigned MAT_DEPTH  = 16;

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_NEAR_W_THRESH = 2'd2;

   localparam logic [DIM_W-1:0] RESET_SCREEN_WIDTH  = 14'd1920;
   localparam logic [DIM_W-1:0] RESET_SCREEN_HEIGHT = 14'd1080;
   localparam logic [THR_W-1:0] RESET_NEAR_W_THRESH = 31'd6554;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PROJECT = 1'b1;

   localparam logic [1:0] ROW_X     = 2'd0;
   localparam logic [1:0] ROW_Y     = 2'd1;
   localparam logic [1:0] ROW_W     = 2'd2;
   localparam logic [1:0] TERM_X    = 2'd0;
   localparam logic [1:0] TERM_Y    = 2'd1;
   localparam logic [1:0] TERM_Z    = 2'd2;
   localparam logic [1:0] TERM_OFS  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OFS,
      ST_MUL,
      ST_ACC,
      ST_SAVE,
      ST_CHECK,
      ST_ABS,
      ST_HLO,
      ST_HHI,
      ST_HSUM,
      ST_DTEST,
      ST_DIV,
      ST_DFIN,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_OFS,
      OP_MUL,
      OP_ACC,
      OP_SAVE,
      OP_ABS,
      OP_HLO,
      OP_HHI,
      OP_HSUM,
      OP_DTEST,
      OP_DSTEP,
      OP_DFIN,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [1:0]           row;
      logic [1:0]           term;
      logic                 coord;
      logic                 visible;
      logic [MAT_IDX_W-1:0] mat_index;
   } ctrl_type;

   typedef struct packed {
      logic invisible;
      logic div_skip;
   } status_type;

endpackage

// ===== src/wsp_matrix_store.sv =====
`timescale 1ns / 1ps

module wsp_matrix_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  write_enable,
   input  logic        [wsp_pkg::MAT_IDX_W-1:0]  write_index,
   input  logic signed [wsp_pkg::COORD_W-1:0]    write_data,
   input  logic        [wsp_pkg::MAT_IDX_W-1:0]  read_index,
   output logic signed [wsp_pkg::COORD_W-1:0]    read_data
);

   logic signed [wsp_pkg::COORD_W-1:0] entry_ff [wsp_pkg::MAT_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wsp_pkg::MAT_DEPTH; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (write_enable) begin
         entry_ff[write_index] <= write_data;
      end
   end

   assign read_data = entry_ff[read_index];

endmodule

// ===== src/wsp_datapath.sv =====
`timescale 1ns / 1ps

module wsp_datapath (
   input  logic                                 clock,
   input  wsp_pkg::ctrl_type                    ctrl,
   input  logic signed [wsp_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [wsp_pkg::COORD_W-1:0]   req_point_y,
   input  logic signed [wsp_pkg::COORD_W-1:0]   req_point_z,
   input  logic signed [wsp_pkg::COORD_W-1:0]   mat_rdata,
   input  logic        [wsp_pkg::HALF_W-1:0]    half_width,
   input  logic        [wsp_pkg::HALF_W-1:0]    half_height,
   input  logic        [wsp_pkg::THR_W-1:0]     near_w_threshold,
   output wsp_pkg::status_type                  status,
   output logic                                 rsp_visible,
   output logic signed [wsp_pkg::COORD_W-1:0]   rsp_screen_x,
   output logic signed [wsp_pkg::COORD_W-1:0]   rsp_screen_y
);

   localparam int unsigned MUL_OP_W = wsp_pkg::COORD_W + 1;
   localparam int unsigned MUL_P_W  = 2 * MUL_OP_W;
   localparam int unsigned PROD_W   = 2 * wsp_pkg::COORD_W;
   localparam int unsigned CHUNK_W  = wsp_pkg::MAG_W / 2;
   localparam int unsigned PART_W   = CHUNK_W + wsp_pkg::HALF_W;
   localparam int unsigned SHIFT_W  = wsp_pkg::DIV_STEPS;
   localparam int unsigned QMAG_W   = wsp_pkg::DIV_STEPS + 1;
   localparam int unsigned SUM_W    = QMAG_W + 2;
   localparam int unsigned LOW_W    = wsp_pkg::DIV_STEPS - wsp_pkg::FRAC_BITS;
   localparam int unsigned CMP_W    = wsp_pkg::MAG_W + LOW_W;

   logic signed [wsp_pkg::COORD_W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [PROD_W-1:0]           prod_ff, prod_in;
   logic signed [wsp_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [wsp_pkg::ACC_W-1:0]   cx_ff, cx_in, cy_ff, cy_in, cw_ff, cw_in;
   logic        [wsp_pkg::MAG_W-1:0]   cabs_ff, cabs_in;
   logic                               neg_ff, neg_in;
   logic        [wsp_pkg::NUM_W-1:0]   n_ff, n_in;
   logic        [wsp_pkg::MAG_W-1:0]   rem_ff, rem_in;
   logic        [SHIFT_W-1:0]          shift_ff, shift_in;
   logic                               qsat_ff, qsat_in, qzero_ff, qzero_in;
   logic signed [wsp_pkg::COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic                               vis_ff, vis_in;
   logic signed [wsp_pkg::COORD_W-1:0] rx_ff, rx_in, ry_ff, ry_in;

   logic signed [MUL_OP_W-1:0]         mul_a, mul_b;
   logic signed [MUL_P_W-1:0]          mul_p;
   logic signed [wsp_pkg::COORD_W-1:0] point_sel;
   logic        [wsp_pkg::HALF_W-1:0]  half_sel;
   logic signed [wsp_pkg::ACC_W-1:0]   coord_sel, coord_neg;
   logic        [wsp_pkg::MAG_W-1:0]   divisor;
   logic                               n_zero, n_ge;
   logic        [wsp_pkg::MAG_W:0]     trial, diff;
   logic                               trial_ge;
   logic        [QMAG_W-1:0]           qmag;
   logic signed [QMAG_W:0]             qsigned;
   logic signed [SUM_W-1:0]            total;
   logic signed [wsp_pkg::COORD_W-1:0] sat_val;

   always_comb begin
      case (ctrl.term)
         wsp_pkg::TERM_X: point_sel = px_ff;
         wsp_pkg::TERM_Y: point_sel = py_ff;
         default:         point_sel = pz_ff;
      endcase
   end

   assign half_sel  = ctrl.coord ? half_height : half_width;
   assign coord_sel = ctrl.coord ? cy_ff : cx_ff;
   assign coord_neg = -coord_sel;
   assign divisor   = cw_ff[wsp_pkg::MAG_W-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         wsp_pkg::OP_MUL: begin
            mul_a = {point_sel[wsp_pkg::COORD_W-1], point_sel};
            mul_b = {mat_rdata[wsp_pkg::COORD_W-1], mat_rdata};
         end
         wsp_pkg::OP_HLO: begin
            mul_a = {{(MUL_OP_W-CHUNK_W){1'b0}}, cabs_ff[CHUNK_W-1:0]};
            mul_b = {{(MUL_OP_W-wsp_pkg::HALF_W){1'b0}}, half_sel};
         end
         wsp_pkg::OP_HHI: begin
            mul_a = {{(MUL_OP_W-CHUNK_W){1'b0}}, cabs_ff[wsp_pkg::MAG_W-1:CHUNK_W]};
            mul_b = {{(MUL_OP_W-wsp_pkg::HALF_W){1'b0}}, half_sel};
         end
         default: begin
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign status.invisible =
      cw_ff < $signed({{(wsp_pkg::ACC_W-wsp_pkg::THR_W){1'b0}}, near_w_threshold});

   assign n_zero = (n_ff == '0);
   assign n_ge   = {{(CMP_W-wsp_pkg::NUM_W){1'b0}}, n_ff} >= {divisor, {LOW_W{1'b0}}};
   assign status.div_skip = n_zero || n_ge;

   assign trial    = {rem_ff, shift_ff[SHIFT_W-1]};
   assign trial_ge = trial >= {1'b0, divisor};
   assign diff     = trial - {1'b0, divisor};

   always_comb begin
      if (qzero_ff) begin
         qmag = '0;
      end else if (qsat_ff) begin
         qmag = {2'b01, {(QMAG_W-2){1'b0}}};
      end else begin
         qmag = {1'b0, shift_ff};
      end
      qsigned = neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      total   = $signed({qsigned[QMAG_W], qsigned})
              + $signed({{(SUM_W-wsp_pkg::HALF_W-wsp_pkg::FRAC_BITS){1'b0}},
                         half_sel, {wsp_pkg::FRAC_BITS{1'b0}}});
      if (total[SUM_W-1:wsp_pkg::COORD_W-1] == '0
          || total[SUM_W-1:wsp_pkg::COORD_W-1] == '1) begin
         sat_val = total[wsp_pkg::COORD_W-1:0];
      end else if (total[SUM_W-1]) begin
         sat_val = {1'b1, {(wsp_pkg::COORD_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(wsp_pkg::COORD_W-1){1'b1}}};
      end
   end

   always_comb begin
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cw_in    = cw_ff;
      cabs_in  = cabs_ff;
      neg_in   = neg_ff;
      n_in     = n_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      qsat_in  = qsat_ff;
      qzero_in = qzero_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      vis_in   = vis_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      case (ctrl.op)
         wsp_pkg::OP_LOAD: begin
            px_in = req_point_x;
            py_in = req_point_y;
            pz_in = req_point_z;
         end
         wsp_pkg::OP_OFS: begin
            acc_in = {{(wsp_pkg::ACC_W-wsp_pkg::COORD_W){mat_rdata[wsp_pkg::COORD_W-1]}},
                      mat_rdata};
         end
         wsp_pkg::OP_MUL: begin
            prod_in = mul_p[PROD_W-1:0];
         end
         wsp_pkg::OP_ACC: begin
            // floor of the Q32.32 product down to Q16.16
            acc_in = acc_ff + {prod_ff[PROD_W-1], prod_ff[PROD_W-1:wsp_pkg::FRAC_BITS]};
         end
         wsp_pkg::OP_SAVE: begin
            case (ctrl.row)
               wsp_pkg::ROW_X: cx_in = acc_ff;
               wsp_pkg::ROW_Y: cy_in = acc_ff;
               default:        cw_in = acc_ff;
            endcase
         end
         wsp_pkg::OP_ABS: begin
            cabs_in = coord_sel[wsp_pkg::ACC_W-1] ? coord_neg[wsp_pkg::MAG_W-1:0]
                                                 : coord_sel[wsp_pkg::MAG_W-1:0];
            // y is mirrored, so its sign flips
            neg_in  = coord_sel[wsp_pkg::ACC_W-1] ^ ctrl.coord;
         end
         wsp_pkg::OP_HLO: begin
            prod_in = mul_p[PROD_W-1:0];
         end
         wsp_pkg::OP_HHI: begin
            n_in    = {{(wsp_pkg::NUM_W-PART_W){1'b0}}, prod_ff[PART_W-1:0]};
            prod_in = mul_p[PROD_W-1:0];
         end
         wsp_pkg::OP_HSUM: begin
            n_in = n_ff + {prod_ff[PART_W-1:0], {CHUNK_W{1'b0}}};
         end
         wsp_pkg::OP_DTEST: begin
            rem_in   = {{(wsp_pkg::MAG_W-(wsp_pkg::NUM_W-LOW_W)){1'b0}},
                        n_ff[wsp_pkg::NUM_W-1:LOW_W]};
            shift_in = {n_ff[LOW_W-1:0], {wsp_pkg::FRAC_BITS{1'b0}}};
            qzero_in = n_zero;
            qsat_in  = !n_zero && n_ge;
         end
         wsp_pkg::OP_DSTEP: begin
            rem_in   = trial_ge ? diff[wsp_pkg::MAG_W-1:0] : trial[wsp_pkg::MAG_W-1:0];
            shift_in = {shift_ff[SHIFT_W-2:0], trial_ge};
         end
         wsp_pkg::OP_DFIN: begin
            if (ctrl.coord) begin
               sy_in = sat_val;
            end else begin
               sx_in = sat_val;
            end
         end
         wsp_pkg::OP_EMIT: begin
            vis_in = ctrl.visible;
            rx_in  = ctrl.visible ? sx_ff : '0;
            ry_in  = ctrl.visible ? sy_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cw_ff    <= cw_in;
      cabs_ff  <= cabs_in;
      neg_ff   <= neg_in;
      n_ff     <= n_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      qsat_ff  <= qsat_in;
      qzero_ff <= qzero_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      vis_ff   <= vis_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
   end

   assign rsp_visible  = vis_ff;
   assign rsp_screen_x = rx_ff;
   assign rsp_screen_y = ry_ff;

endmodule

// ===== src/wsp_sequencer.sv =====
`timescale 1ns / 1ps

module wsp_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   input  logic                rsp_stall,
   input  wsp_pkg::status_type status,
   output logic                req_stall,
   output logic                rsp_valid,
   output wsp_pkg::ctrl_type   ctrl
);

   wsp_pkg::state_type          state_ff, state_in;
   logic [1:0]                  row_ff, row_in;
   logic [1:0]                  term_ff, term_in;
   logic                        coord_ff, coord_in;
   logic [wsp_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        vis_ff, vis_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        project_accept;
   logic                        out_free;
   logic [1:0]                  row_index;

   assign req_stall      = (state_ff != wsp_pkg::ST_IDLE);
   assign project_accept = req_valid && !req_stall && (req_mode == wsp_pkg::MODE_PROJECT);
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   // clip rows x, y, w live in matrix rows 0, 1, 3
   assign row_index      = {row_ff[1], row_ff[1] | row_ff[0]};

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      term_in      = term_ff;
      coord_in     = coord_ff;
      step_in      = step_ff;
      vis_in       = vis_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         wsp_pkg::ST_IDLE: begin
            if (project_accept) begin
               state_in = wsp_pkg::ST_OFS;
               row_in   = wsp_pkg::ROW_X;
            end
         end
         wsp_pkg::ST_OFS: begin
            state_in = wsp_pkg::ST_MUL;
            term_in  = wsp_pkg::TERM_X;
         end
         wsp_pkg::ST_MUL: begin
            state_in = wsp_pkg::ST_ACC;
         end
         wsp_pkg::ST_ACC: begin
            if (term_ff == wsp_pkg::TERM_Z) begin
               state_in = wsp_pkg::ST_SAVE;
            end else begin
               state_in = wsp_pkg::ST_MUL;
               term_in  = term_ff + 2'd1;
            end
         end
         wsp_pkg::ST_SAVE: begin
            if (row_ff == wsp_pkg::ROW_W) begin
               state_in = wsp_pkg::ST_CHECK;
            end else begin
               state_in = wsp_pkg::ST_OFS;
               row_in   = row_ff + 2'd1;
            end
         end
         wsp_pkg::ST_CHECK: begin
            vis_in   = !status.invisible;
            coord_in = 1'b0;
            state_in = status.invisible ? wsp_pkg::ST_OUT : wsp_pkg::ST_ABS;
         end
         wsp_pkg::ST_ABS:  state_in = wsp_pkg::ST_HLO;
         wsp_pkg::ST_HLO:  state_in = wsp_pkg::ST_HHI;
         wsp_pkg::ST_HHI:  state_in = wsp_pkg::ST_HSUM;
         wsp_pkg::ST_HSUM: state_in = wsp_pkg::ST_DTEST;
         wsp_pkg::ST_DTEST: begin
            step_in  = '0;
            state_in = status.div_skip ? wsp_pkg::ST_DFIN : wsp_pkg::ST_DIV;
         end
         wsp_pkg::ST_DIV: begin
            if (step_ff == wsp_pkg::STEP_W'(wsp_pkg::DIV_STEPS - 1)) begin
               state_in = wsp_pkg::ST_DFIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         wsp_pkg::ST_DFIN: begin
            if (coord_ff) begin
               state_in = wsp_pkg::ST_OUT;
            end else begin
               coord_in = 1'b1;
               state_in = wsp_pkg::ST_ABS;
            end
         end
         wsp_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = wsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.row       = row_ff;
      ctrl.term      = term_ff;
      ctrl.coord     = coord_ff;
      ctrl.visible   = vis_ff;
      ctrl.mat_index = {term_ff, row_index};
      ctrl.op        = wsp_pkg::OP_NONE;
      case (state_ff)
         wsp_pkg::ST_IDLE: begin
            if (project_accept) begin
               ctrl.op = wsp_pkg::OP_LOAD;
            end
         end
         wsp_pkg::ST_OFS: begin
            ctrl.op        = wsp_pkg::OP_OFS;
            ctrl.mat_index = {wsp_pkg::TERM_OFS, row_index};
         end
         wsp_pkg::ST_MUL:   ctrl.op = wsp_pkg::OP_MUL;
         wsp_pkg::ST_ACC:   ctrl.op = wsp_pkg::OP_ACC;
         wsp_pkg::ST_SAVE:  ctrl.op = wsp_pkg::OP_SAVE;
         wsp_pkg::ST_ABS:   ctrl.op = wsp_pkg::OP_ABS;
         wsp_pkg::ST_HLO:   ctrl.op = wsp_pkg::OP_HLO;
         wsp_pkg::ST_HHI:   ctrl.op = wsp_pkg::OP_HHI;
         wsp_pkg::ST_HSUM:  ctrl.op = wsp_pkg::OP_HSUM;
         wsp_pkg::ST_DTEST: ctrl.op = wsp_pkg::OP_DTEST;
         wsp_pkg::ST_DIV:   ctrl.op = wsp_pkg::OP_DSTEP;
         wsp_pkg::ST_DFIN:  ctrl.op = wsp_pkg::OP_DFIN;
         wsp_pkg::ST_OUT: begin
            if (out_free) begin
               ctrl.op = wsp_pkg::OP_EMIT;
            end
         end
         default: begin
            ctrl.op = wsp_pkg::OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsp_pkg::ST_IDLE;
         row_ff       <= '0;
         term_ff      <= '0;
         coord_ff     <= 1'b0;
         step_ff      <= '0;
         vis_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         term_ff      <= term_in;
         coord_ff     <= coord_in;
         step_ff      <= step_in;
         vis_ff       <= vis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == wsp_pkg::OP_EMIT |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result beat overwritten while held");

   a_project_starts: assert property (@(posedge clock) disable iff (reset)
      project_accept |=> (state_ff == wsp_pkg::ST_OFS && row_ff == wsp_pkg::ROW_X))
      else $error("projection did not start at clip x row");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == wsp_pkg::ST_DIV |-> step_ff < wsp_pkg::STEP_W'(wsp_pkg::DIV_STEPS))
      else $error("divide step counter overran");

   a_divide_visible: assert property (@(posedge clock) disable iff (reset)
      state_ff == wsp_pkg::ST_ABS |-> vis_ff)
      else $error("divide entered for invisible point");

endmodule

// ===== src/world_to_screen_projection_unit.sv =====
`timescale 1ns / 1ps
// Sequence: a load beat writes one matrix entry; a project beat, when visible, runs
// 9 MACs plus offsets, then two 33-step divides on the shared subtractor (a divide whose
// quotient is zero or saturates is skipped); when clip w is below the threshold the
// divides are not run. A project beat holds off new beats until its result is registered
// at the output; load beats are taken every cycle while the unit is idle.
// Reset (synchronous, active high) clears the matrix, restores the viewport registers.

module world_to_screen_projection_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic        [wsp_pkg::MAT_IDX_W-1:0] req_entry_index,
   input  logic signed [wsp_pkg::COORD_W-1:0]  req_entry_value,
   input  logic signed [wsp_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [wsp_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [wsp_pkg::COORD_W-1:0]  req_point_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_visible,
   output logic signed [wsp_pkg::COORD_W-1:0]  rsp_screen_x,
   output logic signed [wsp_pkg::COORD_W-1:0]  rsp_screen_y,
   input  logic                                csr_wen,
   input  logic        [1:0]                   csr_index,
   input  logic        [wsp_pkg::CSR_W-1:0]    csr_wdata
);

   logic [wsp_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [wsp_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [wsp_pkg::THR_W-1:0]  thresh_ff, thresh_in;

   wsp_pkg::ctrl_type                  ctrl;
   wsp_pkg::status_type                status;
   logic signed [wsp_pkg::COORD_W-1:0] mat_rdata;
   logic                               load_write;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_wen) begin
         case (csr_index)
            wsp_pkg::CSR_SCREEN_WIDTH:  width_in  = csr_wdata[wsp_pkg::DIM_W-1:0];
            wsp_pkg::CSR_SCREEN_HEIGHT: height_in = csr_wdata[wsp_pkg::DIM_W-1:0];
            wsp_pkg::CSR_NEAR_W_THRESH: thresh_in = csr_wdata[wsp_pkg::THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= wsp_pkg::RESET_SCREEN_WIDTH;
         height_ff <= wsp_pkg::RESET_SCREEN_HEIGHT;
         thresh_ff <= wsp_pkg::RESET_NEAR_W_THRESH;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thresh_ff <= thresh_in;
      end
   end

   assign load_write = req_valid && !req_stall && (req_mode == wsp_pkg::MODE_LOAD);

   wsp_matrix_store u_matrix (
      .clock        (clock),
      .reset        (reset),
      .write_enable (load_write),
      .write_index  (req_entry_index),
      .write_data   (req_entry_value),
      .read_index   (ctrl.mat_index),
      .read_data    (mat_rdata)
   );

   wsp_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   wsp_datapath u_dp (
      .clock            (clock),
      .ctrl             (ctrl),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .mat_rdata        (mat_rdata),
      .half_width       (width_ff[wsp_pkg::DIM_W-1:1]),
      .half_height      (height_ff[wsp_pkg::DIM_W-1:1]),
      .near_w_threshold (thresh_ff),
      .status           (status),
      .rsp_visible      (rsp_visible),
      .rsp_screen_x     (rsp_screen_x),
      .rsp_screen_y     (rsp_screen_y)
   );

endmodule

// ===== dv/tb_world_to_screen_projection_unit.sv =====
`timescale 1ns / 1ps

module tb_world_to_screen_projection_unit;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES    = 600;
   localparam int unsigned HOLD_AT_RESULT = 30;
   localparam int unsigned SETTLE_CYCLES  = 10;
   localparam int unsigned DRAIN_CYCLES   = 120;

   typedef enum int {PACE_SEND_LIGHT, PACE_SEND_HEAVY, PACE_NONE} pace_type;

   typedef struct {
      logic                               mode;
      logic [wsp_pkg::MAT_IDX_W-1:0]      idx;
      logic signed [wsp_pkg::COORD_W-1:0] ev, px, py, pz;
   } proj_req_type;

   typedef struct packed {
      logic                               visible;
      logic signed [wsp_pkg::COORD_W-1:0] sx;
      logic signed [wsp_pkg::COORD_W-1:0] sy;
   } screen_pt_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_mode = wsp_pkg::MODE_LOAD;
   logic [wsp_pkg::MAT_IDX_W-1:0]      req_entry_index = '0;
   logic signed [wsp_pkg::COORD_W-1:0] req_entry_value = '0;
   logic signed [wsp_pkg::COORD_W-1:0] req_point_x = '0;
   logic signed [wsp_pkg::COORD_W-1:0] req_point_y = '0;
   logic signed [wsp_pkg::COORD_W-1:0] req_point_z = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_visible;
   logic signed [wsp_pkg::COORD_W-1:0] rsp_screen_x;
   logic signed [wsp_pkg::COORD_W-1:0] rsp_screen_y;
   logic                               csr_wen = 1'b0;
   logic [1:0]                         csr_index = '0;
   logic [wsp_pkg::CSR_W-1:0]          csr_wdata = '0;

   world_to_screen_projection_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_visible     (rsp_visible),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // projection state mirror
   longint                     mat_q [wsp_pkg::MAT_DEPTH];
   logic [wsp_pkg::DIM_W-1:0]  vp_width  = wsp_pkg::RESET_SCREEN_WIDTH;
   logic [wsp_pkg::DIM_W-1:0]  vp_height = wsp_pkg::RESET_SCREEN_HEIGHT;
   logic [wsp_pkg::THR_W-1:0]  near_thr  = wsp_pkg::RESET_NEAR_W_THRESH;

   proj_req_type  pending_beats [$];
   screen_pt_type expected_pts [$];
   proj_req_type  cur_beat;
   pace_type      pace = PACE_SEND_LIGHT;
   int unsigned   errors = 0;
   int unsigned   results_seen = 0;

   initial begin
      for (int i = 0; i < wsp_pkg::MAT_DEPTH; i++) begin
         mat_q[i] = 0;
      end
   end

   // Q16.16 product, floor
   function automatic longint mul_q16(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> wsp_pkg::FRAC_BITS;
   endfunction

   // half*c/w as Q16.16 on magnitudes, truncated, clamped to 2^33
   function automatic longint div_q16(longint unsigned half, longint c, longint w);
      logic neg;
      longint unsigned n, d, q, r;
      neg = 1'b0;
      if (c < 0) begin
         neg = ~neg;
         n = -c;
      end else begin
         n = c;
      end
      if (w < 0) begin
         neg = ~neg;
         d = -w;
      end else begin
         d = w;
      end
      n = n * half;
      if (n == 0) return 0;
      if (d == 0) begin
         q = 64'd1 << 33;
      end else begin
         q = n / d;
         r = n % d;
         if (q >= (64'd1 << 17)) begin
            q = 64'd1 << 33;
         end else begin
            for (int k = 0; k < wsp_pkg::FRAC_BITS; k++) begin
               r = r << 1;
               q = q << 1;
               if (r >= d) begin
                  r = r - d;
                  q = q | 64'd1;
               end
            end
         end
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [wsp_pkg::COORD_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[wsp_pkg::COORD_W-1:0];
   endfunction

   function automatic screen_pt_type project_point(logic signed [wsp_pkg::COORD_W-1:0] x, y, z);
      longint cx, cy, cw, lx, ly, lz;
      longint unsigned hw, hh;
      screen_pt_type o;
      o = '0;
      lx = longint'(x);
      ly = longint'(y);
      lz = longint'(z);
      cx = mul_q16(lx, mat_q[0]) + mul_q16(ly, mat_q[4]) + mul_q16(lz, mat_q[8]) + mat_q[12];
      cy = mul_q16(lx, mat_q[1]) + mul_q16(ly, mat_q[5]) + mul_q16(lz, mat_q[9]) + mat_q[13];
      cw = mul_q16(lx, mat_q[3]) + mul_q16(ly, mat_q[7]) + mul_q16(lz, mat_q[11]) + mat_q[15];
      if (cw < longint'(near_thr)) return o;
      hw = longint'(vp_width >> 1);
      hh = longint'(vp_height >> 1);
      o.visible = 1'b1;
      o.sx = clamp32(div_q16(hw, cx, cw) + longint'(hw << wsp_pkg::FRAC_BITS));
      o.sy = clamp32(-div_q16(hh, cy, cw) + longint'(hh << wsp_pkg::FRAC_BITS));
      return o;
   endfunction

   function automatic void apply_beat(proj_req_type b);
      if (b.mode == wsp_pkg::MODE_LOAD) begin
         mat_q[b.idx] = longint'(b.ev);
      end else begin
         expected_pts.push_back(project_point(b.px, b.py, b.pz));
      end
   endfunction

   function automatic logic signed [wsp_pkg::COORD_W-1:0] rand_span(int unsigned mag);
      return int'($urandom_range(0, 2 * mag)) - int'(mag);
   endfunction

   function automatic logic signed [wsp_pkg::COORD_W-1:0] edge_val();
      case ($urandom_range(4))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0000_0000;
         3: return 32'sh0001_0000;
         default: return 32'shFFFF_FFFF;
      endcase
   endfunction

   // plausible perspective matrix entry, column-major
   function automatic logic signed [wsp_pkg::COORD_W-1:0] sane_entry(int unsigned i);
      case (i)
         0, 5:   return rand_span(4 << wsp_pkg::FRAC_BITS);
         11:     return 32'sh0001_0000 + rand_span(8192);
         15:     return rand_span(1 << 15);
         12, 13: return rand_span(16 << wsp_pkg::FRAC_BITS);
         3, 7:   return rand_span(3277);
         default: return rand_span(1 << 15);
      endcase
   endfunction

   function automatic proj_req_type load_beat(int unsigned i,
                                              logic signed [wsp_pkg::COORD_W-1:0] v);
      proj_req_type b;
      b.mode = wsp_pkg::MODE_LOAD;
      b.idx  = wsp_pkg::MAT_IDX_W'(i);
      b.ev   = v;
      b.px   = $urandom;
      b.py   = $urandom;
      b.pz   = $urandom;
      return b;
   endfunction

   function automatic proj_req_type point_beat(logic signed [wsp_pkg::COORD_W-1:0] x, y, z);
      proj_req_type b;
      b.mode = wsp_pkg::MODE_PROJECT;
      b.idx  = wsp_pkg::MAT_IDX_W'($urandom_range(wsp_pkg::MAT_DEPTH - 1));
      b.ev   = $urandom;
      b.px   = x;
      b.py   = y;
      b.pz   = z;
      return b;
   endfunction

   function automatic proj_req_type random_point();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) begin
         return point_beat(rand_span(64 << wsp_pkg::FRAC_BITS),
                           rand_span(64 << wsp_pkg::FRAC_BITS),
                           int'($urandom_range(0, 256 << wsp_pkg::FRAC_BITS))
                           - (16 << wsp_pkg::FRAC_BITS));
      end else if (r < 80) begin
         return point_beat($urandom, $urandom, $urandom);
      end else if (r < 90) begin
         return point_beat(rand_span(4), rand_span(4), rand_span(8));
      end
      return point_beat(edge_val(), edge_val(), edge_val());
   endfunction

   task automatic queue_random(int unsigned n);
      int unsigned cnt, r;
      cnt = 0;
      while (cnt < n) begin
         r = $urandom_range(99);
         if (r < 4) begin
            for (int i = 0; i < wsp_pkg::MAT_DEPTH; i++) begin
               pending_beats.push_back(load_beat(i, sane_entry(i)));
            end
            cnt += wsp_pkg::MAT_DEPTH;
         end else if (r < 12) begin
            r = $urandom_range(wsp_pkg::MAT_DEPTH - 1);
            pending_beats.push_back(load_beat(r, sane_entry(r)));
            cnt++;
         end else if (r < 17) begin
            pending_beats.push_back(load_beat($urandom_range(wsp_pkg::MAT_DEPTH - 1),
                                              $urandom));
            cnt++;
         end else begin
            pending_beats.push_back(random_point());
            cnt++;
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_pts.size() != 0);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [wsp_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         wsp_pkg::CSR_SCREEN_WIDTH:  vp_width  = val[wsp_pkg::DIM_W-1:0];
         wsp_pkg::CSR_SCREEN_HEIGHT: vp_height = val[wsp_pkg::DIM_W-1:0];
         wsp_pkg::CSR_NEAR_W_THRESH: near_thr  = val[wsp_pkg::THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_viewport(int unsigned w, int unsigned h, int unsigned thr,
                               pace_type p);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(wsp_pkg::CSR_SCREEN_WIDTH, wsp_pkg::CSR_W'(w));
      write_csr(wsp_pkg::CSR_SCREEN_HEIGHT, wsp_pkg::CSR_W'(h));
      write_csr(wsp_pkg::CSR_NEAR_W_THRESH, wsp_pkg::CSR_W'(thr));
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
      pace = p;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: simple perspective matrix, boundary and saturating points
      pending_beats.push_back(load_beat(0, 32'sh0001_0000));
      pending_beats.push_back(load_beat(5, 32'sh0001_0000));
      pending_beats.push_back(load_beat(11, 32'sh0001_0000));
      pending_beats.push_back(point_beat(0, 0, 32'sh0001_0000));
      pending_beats.push_back(point_beat(32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000));
      pending_beats.push_back(point_beat(0, 0, 0));
      pending_beats.push_back(point_beat(0, 0, -32'sh0001_0000));
      pending_beats.push_back(point_beat(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000));
      pending_beats.push_back(point_beat(32'sh0001_0000, 32'sh0001_0000, 6554));
      pending_beats.push_back(point_beat(32'sh0001_0000, 32'sh0001_0000, 6553));
      pending_beats.push_back(point_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      pending_beats.push_back(point_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
      pending_beats.push_back(load_beat(15, 32'sh7FFF_FFFF));
      pending_beats.push_back(load_beat(12, 32'sh8000_0000));
      pending_beats.push_back(point_beat(0, 0, 0));
      pending_beats.push_back(load_beat(3, 32'shFFFF_FFFF));
      pending_beats.push_back(point_beat(3, -5, 7));

      // zero threshold: clip w of zero, with zero and nonzero numerator
      set_viewport(640, 480, 0, PACE_SEND_LIGHT);
      pending_beats.push_back(load_beat(3, 0));
      pending_beats.push_back(load_beat(12, 0));
      pending_beats.push_back(load_beat(15, 0));
      pending_beats.push_back(point_beat(0, 0, 0));
      pending_beats.push_back(point_beat(32'sh0001_0000, -32'sh0001_0000, 0));
      queue_random(350);

      set_viewport(8192, 8192, 6554, PACE_SEND_LIGHT);
      queue_random(300);
      set_viewport(1, 1, 32'h0001_0000, PACE_SEND_HEAVY);
      queue_random(300);
      set_viewport(0, 16383, 32'h7FFF_FFFF, PACE_SEND_HEAVY);
      queue_random(100);
      set_viewport($urandom_range(16383), $urandom_range(16383), $urandom_range(1 << 18),
                   PACE_NONE);
      queue_random(350);
      set_viewport(2, 3, 1, PACE_NONE);
      queue_random(350);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(posedge clock) begin : driver
      proj_req_type nxt;
      logic fire, gap;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) apply_beat(cur_beat);
         case (pace)
            PACE_SEND_LIGHT: gap = $urandom_range(99) < 26;
            PACE_SEND_HEAVY: gap = $urandom_range(99) < 56;
            default:         gap = 1'b0;
         endcase
         if (!req_valid || fire) begin
            if (pending_beats.size() != 0 && !gap) begin
               nxt = pending_beats.pop_front();
               cur_beat = nxt;
               req_valid       <= 1'b1;
               req_mode        <= nxt.mode;
               req_entry_index <= nxt.idx;
               req_entry_value <= nxt.ev;
               req_point_x     <= nxt.px;
               req_point_y     <= nxt.py;
               req_point_z     <= nxt.pz;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      screen_pt_type exp_pt;
      int unsigned hold_left;
      logic hold_done, stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_pts.size() == 0) begin
               $error("unexpected result beat: visible=%0d x=%0d y=%0d",
                      rsp_visible, rsp_screen_x, rsp_screen_y);
               errors++;
            end else begin
               exp_pt = expected_pts.pop_front();
               if (rsp_visible !== exp_pt.visible) begin
                  $error("visible: expected %0d, got %0d", exp_pt.visible, rsp_visible);
                  errors++;
               end
               if (rsp_screen_x !== exp_pt.sx) begin
                  $error("screen_x: expected %0d, got %0d", exp_pt.sx, rsp_screen_x);
                  errors++;
               end
               if (rsp_screen_y !== exp_pt.sy) begin
                  $error("screen_y: expected %0d, got %0d", exp_pt.sy, rsp_screen_y);
                  errors++;
               end
            end
         end
         // one long hold-off so the block backs up into its input
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (!hold_done && results_seen == HOLD_AT_RESULT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            stall_next = 1'b1;
         end else begin
            case (pace)
               PACE_SEND_LIGHT: stall_next = $urandom_range(99) < 56;
               PACE_SEND_HEAVY: stall_next = $urandom_range(99) < 26;
               default:         stall_next = 1'b0;
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin : watchdog
      int unsigned quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

endmodule
